// File: design/pka_pkg.sv
// ----------------------------------------------------------------------------
// pka_pkg
// shared types and constants of the protection key allocator
// ----------------------------------------------------------------------------
package pka_pkg;

  localparam int NUM_KEYS_DEFAULT = 16;
  localparam int KEY_IDX_W        = 5;
  localparam int KEY_W            = 4;
  localparam int REQ_W            = 4;
  localparam int RIGHTS_W         = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_SET    = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DISABLED   = 3'd1,
    ST_BAD_KEY    = 3'd2,
    ST_NOT_ALLOC  = 3'd3,
    ST_NONE_FREE  = 3'd4,
    ST_BAD_RIGHTS = 3'd5
  } status_t;

  // command token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    cmd_t                  cmd;
    logic [KEY_IDX_W-1:0]  key;
    logic [REQ_W-1:0]      req;
    logic                  enabled;
    status_t               status;
    logic [KEY_W-1:0]      kres;
    logic [RIGHTS_W-1:0]   rres;
  } pkt_t;

endpackage

// File: design/protection_key_allocator.sv
// ----------------------------------------------------------------------------
// protection_key_allocator
// protection key bitmap and rights word, built as a chain of key cells
// ----------------------------------------------------------------------------
//
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | in_valid in_ready command key_index       | into block
//          | rights_request                            |
// out      | out_valid out_ready status key_result     | out of block
//          | rights_result                             |
// cfg      | cfg_valid cfg_ready cfg_data              | into block
//
// a command transfer loads the token register; the token then walks one
// key cell per cycle and then lands in the output register. one command
// is in the chain at a time: the next input transfer can happen once the
// result sits in the output register, in the same cycle as the result
// transfer when out_ready is high. a stalled result holds in_ready low
// only if the chain is empty and the output register is still full. reset
// clears every key cell, keys_enabled and the valid flags; cfg_ready is
// always high.
//
module protection_key_allocator
  import pka_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [KEY_IDX_W-1:0] key_index,
  input  logic [REQ_W-1:0]     rights_request,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [KEY_W-1:0]     key_result,
  output logic [RIGHTS_W-1:0]  rights_result,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic                keys_enabled;
  pkt_t                stage [NUM_KEYS+1];
  logic [NUM_KEYS:0]   stage_valids;
  logic                busy;
  pkt_t                inj;
  logic                key_ok;
  logic                req_ok;
  cmd_t                cmd;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keys_enabled <= cfg_data;
    end
  end

  // token in flight anywhere in the chain
  genvar g;
  generate
    for (g = 0; g <= NUM_KEYS; g++) begin : g_valids
      assign stage_valids[g] = stage[g].valid;
    end
  endgenerate
  assign busy = |stage_valids;

  // output register must be free by the time the token comes out
  assign in_ready = !busy && (!out_valid || out_ready);

  // build the token: range, enable and rights checks are settled up front,
  // cells only resolve what depends on their own key
  assign cmd    = cmd_t'(command);
  assign key_ok = (key_index < KEY_IDX_W'(NUM_KEYS));
  assign req_ok = (rights_request[REQ_W-1:RIGHTS_W] == '0);

  always_comb begin
    inj         = '0;
    inj.valid   = 1'b1;
    inj.cmd     = cmd;
    inj.key     = key_index;
    inj.req     = rights_request;
    inj.enabled = keys_enabled;
    inj.status  = ST_OK;
    if (cmd == CMD_FREE) begin
      // free still works with keys disabled
      inj.status = key_ok ? ST_NOT_ALLOC : ST_BAD_KEY;
    end else if (!keys_enabled) begin
      inj.status = ST_DISABLED;
    end else if (cmd == CMD_ALLOC) begin
      inj.status = ST_NONE_FREE;
    end else if (!key_ok) begin
      inj.status = ST_BAD_KEY;
    end else if (cmd == CMD_SET && !req_ok) begin
      inj.status = ST_BAD_RIGHTS;
    end
  end

  // token register at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else begin
      stage[0].valid <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      stage[0].cmd     <= inj.cmd;
      stage[0].key     <= inj.key;
      stage[0].req     <= inj.req;
      stage[0].enabled <= inj.enabled;
      stage[0].status  <= inj.status;
      stage[0].kres    <= inj.kres;
      stage[0].rres    <= inj.rres;
    end
  end

  // one cell per key, token passes from cell i to cell i+1
  generate
    for (g = 0; g < NUM_KEYS; g++) begin : g_cells
      pka_cell #(
        .INDEX (g)
      ) u_cell (
        .clk   (clk),
        .rst   (rst),
        .pkt_i (stage[g]),
        .pkt_o (stage[g+1])
      );
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage[NUM_KEYS].valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (stage[NUM_KEYS].valid) begin
      status        <= stage[NUM_KEYS].status;
      key_result    <= stage[NUM_KEYS].kres;
      rights_result <= stage[NUM_KEYS].rres;
    end
  end

  // at most one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stage_valids))
    else $error("more than one command token in the key chain");

  // a finished token never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stage[NUM_KEYS].valid |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  // a granted key is never key 0
  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    (stage[NUM_KEYS].valid && stage[NUM_KEYS].cmd == CMD_ALLOC &&
     stage[NUM_KEYS].status == ST_OK) |-> (stage[NUM_KEYS].kres != '0))
    else $error("allocate granted the reserved key");

  // the token leaving the chain shows up as a result next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    stage[NUM_KEYS].valid |=> out_valid)
    else $error("finished command did not reach the result register");

endmodule

// File: design/pka_cell.sv
// ----------------------------------------------------------------------------
// pka_cell
// one key slot: allocated bit and two rights bits, acts on a passing token
// ----------------------------------------------------------------------------
module pka_cell
  import pka_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  input  pkt_t pkt_i,
  output pkt_t pkt_o
);

  logic                alloc;
  logic                alloc_next;
  logic [RIGHTS_W-1:0] rights;
  logic [RIGHTS_W-1:0] rights_next;
  pkt_t                pkt_next;
  logic                hit;

  assign hit = (pkt_i.key == KEY_IDX_W'(INDEX));

  always_comb begin
    pkt_next    = pkt_i;
    alloc_next  = alloc;
    rights_next = rights;
    if (pkt_i.valid) begin
      case (pkt_i.cmd)
        CMD_FREE: begin
          if (hit && pkt_i.status == ST_NOT_ALLOC && alloc) begin
            alloc_next      = 1'b0;
            pkt_next.status = ST_OK;
            if (pkt_i.enabled) begin
              rights_next = '0;
            end
          end
        end
        CMD_ALLOC: begin
          // key 0 is reserved, first free slot takes the token
          if ((INDEX != 0) && pkt_i.status == ST_NONE_FREE && !alloc) begin
            alloc_next      = 1'b1;
            pkt_next.status = ST_OK;
            pkt_next.kres   = KEY_W'(INDEX);
            if (pkt_i.req != '0 && pkt_i.req[REQ_W-1:RIGHTS_W] == '0) begin
              rights_next = pkt_i.req[RIGHTS_W-1:0];
            end
          end
        end
        CMD_SET: begin
          if (hit && pkt_i.status == ST_OK) begin
            rights_next = pkt_i.req[RIGHTS_W-1:0];
          end
        end
        CMD_GET: begin
          if (hit && pkt_i.status == ST_OK) begin
            pkt_next.rres = rights;
          end
        end
        default: begin
          pkt_next = pkt_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc       <= 1'b0;
      rights      <= '0;
      pkt_o.valid <= 1'b0;
    end else begin
      alloc       <= alloc_next;
      rights      <= rights_next;
      pkt_o.valid <= pkt_next.valid;
    end
    pkt_o.cmd     <= pkt_next.cmd;
    pkt_o.key     <= pkt_next.key;
    pkt_o.req     <= pkt_next.req;
    pkt_o.enabled <= pkt_next.enabled;
    pkt_o.status  <= pkt_next.status;
    pkt_o.kres    <= pkt_next.kres;
    pkt_o.rres    <= pkt_next.rres;
  end

endmodule
